### rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// Fraction reduce and compare: shared package
// Sequencer states used by the top level of the fraction reduce and compare
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_LD,
    ST_GCD,
    ST_DIVN_LD,
    ST_DIVN,
    ST_DIVD_LD,
    ST_DIVD,
    ST_MUL_L,
    ST_MUL_R,
    ST_DONE
  } frc_state_e;

endpackage

`default_nettype wire

### rtl/frc_gcd.sv
// ----------------------------------------------------------------------------
// Fraction reduce and compare: binary GCD unit
// Finds the greatest common divisor of two magnitudes with one shift or one
// subtraction per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_gcd #(
  parameter int MagBits = 31
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire logic [MagBits-1:0] u_i,
  input  wire logic [MagBits-1:0] v_i,
  output logic                    done_o,
  output logic [MagBits-1:0]      gcd_o
);

  localparam int KW = $clog2(MagBits + 1);

  logic               run_q;
  logic [MagBits-1:0] u_q, v_q, g_q;
  logic [KW-1:0]      k_q;
  logic               u_ge_v;

  assign u_ge_v = (u_q >= v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (load_i) begin
      run_q <= 1'b1;
    end else if (run_q && ((u_q == '0) || (v_q == '0))) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      u_q <= u_i;
      v_q <= v_i;
      k_q <= '0;
    end else if (run_q) begin
      if ((u_q == '0) || (v_q == '0)) begin
        g_q <= (u_q | v_q) << k_q;
      end else if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + KW'(1);
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_ge_v) begin
        u_q <= u_q - v_q;
      end else begin
        v_q <= v_q - u_q;
      end
    end
  end

  assign done_o = !run_q;
  assign gcd_o  = g_q;

endmodule

`default_nettype wire

### rtl/frc_div.sv
// ----------------------------------------------------------------------------
// Fraction reduce and compare: restoring divider
// Unsigned division producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_div #(
  parameter int MagBits = 31
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire logic [MagBits-1:0] dividend_i,
  input  wire logic [MagBits-1:0] divisor_i,
  output logic                    done_o,
  output logic [MagBits-1:0]      quotient_o
);

  localparam int CW = $clog2(MagBits + 1);

  logic               run_q;
  logic [CW-1:0]      cnt_q;
  logic [MagBits-1:0] rem_q, quo_q, dsr_q;
  logic [MagBits:0]   rem_sh, rem_sub;
  logic               fits;

  assign rem_sh  = {rem_q, quo_q[MagBits-1]};
  assign fits    = (rem_sh >= {1'b0, dsr_q});
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (load_i) begin
      run_q <= 1'b1;
      cnt_q <= CW'(MagBits);
    end else if (run_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? rem_sub[MagBits-1:0] : rem_sh[MagBits-1:0];
      quo_q <= {quo_q[MagBits-2:0], fits};
    end
  end

  assign done_o     = !run_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### rtl/fraction_reduce_and_compare.sv
// ----------------------------------------------------------------------------
// Fraction reduce and compare: top level
// Reduces two signed fractions by their GCD and compares them exactly.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; busy_o stays high
// until the single result beat, marked by valid_o for one cycle, has been
// shown, and the receiver cannot hold it off. Each fraction goes through a
// binary GCD unit (one shift or subtraction a cycle) and then twice through a
// restoring divider, first for the numerator and then for the denominator,
// with a load state before each unit run, and the cross products are then
// formed one after the other on one shared multiplier. An item with a zero
// denominator is answered in the cycle right after it is taken.
`default_nettype none

module fraction_reduce_and_compare import frc_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] num_a_i,
  input  wire logic [31:0] den_a_i,
  input  wire logic [31:0] num_b_i,
  input  wire logic [31:0] den_b_i,
  output logic             valid_o,
  output logic [31:0]      red_num_a_o,
  output logic [30:0]      red_den_a_o,
  output logic [31:0]      red_num_b_o,
  output logic [30:0]      red_den_b_o,
  output logic             is_equal_o,
  output logic             a_greater_o,
  output logic [31:0]      max_num_o,
  output logic [30:0]      max_den_o,
  output logic             zero_den_error_o
);

  localparam int W  = VALUE_BITS;
  localparam int MW = VALUE_BITS - 1;

  function automatic logic [W-1:0] take_val(input logic [31:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    if (v == {1'b1, {MW{1'b0}}}) begin
      v = {1'b1, {(MW-1){1'b0}}, 1'b1};
    end
    return v;
  endfunction

  function automatic logic [MW-1:0] mag_of(input logic [W-1:0] v);
    logic [W-1:0] n;
    n = v[W-1] ? (W'(0) - v) : v;
    return n[MW-1:0];
  endfunction

  frc_state_e state_q, state_d;

  logic [W-1:0]  na_v, da_v, nb_v, db_v;
  logic          zero_den;
  logic          accept;

  logic [MW-1:0] mag_na_q, mag_da_q, mag_nb_q, mag_db_q;
  logic          neg_na_q, neg_da_q, neg_nb_q, neg_db_q;
  logic          sel_q, err_q;
  logic [MW-1:0] qn_q;

  logic signed [W-1:0]   rn_a_q, rn_b_q;
  logic [MW-1:0]         rd_a_q, rd_b_q;
  logic signed [2*W-1:0] left_q, right_q;

  logic [MW-1:0] cur_num, cur_den;
  logic          cur_neg;
  logic          gcd_load, gcd_done;
  logic [MW-1:0] gcd_val;
  logic          div_load, div_done;
  logic [MW-1:0] div_dividend, div_quo;
  logic [W-1:0]  qn_ext, rn_new;

  logic signed [W-1:0]   mul_x;
  logic signed [W-1:0]   mul_y;
  logic signed [2*W-1:0] mul_p;

  logic eq, gt;

  assign na_v     = take_val(num_a_i);
  assign da_v     = take_val(den_a_i);
  assign nb_v     = take_val(num_b_i);
  assign db_v     = take_val(den_b_i);
  assign zero_den = (da_v == '0) || (db_v == '0);
  assign accept   = start_i && !busy_o;

  assign cur_num = sel_q ? mag_nb_q : mag_na_q;
  assign cur_den = sel_q ? mag_db_q : mag_da_q;
  assign cur_neg = sel_q ? (neg_nb_q ^ neg_db_q) : (neg_na_q ^ neg_da_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = zero_den ? ST_DONE : ST_GCD_LD;
        end
      end
      ST_GCD_LD:  state_d = ST_GCD;
      ST_GCD: begin
        if (gcd_done) begin
          state_d = ST_DIVN_LD;
        end
      end
      ST_DIVN_LD: state_d = ST_DIVN;
      ST_DIVN: begin
        if (div_done) begin
          state_d = ST_DIVD_LD;
        end
      end
      ST_DIVD_LD: state_d = ST_DIVD;
      ST_DIVD: begin
        if (div_done) begin
          state_d = sel_q ? ST_MUL_L : ST_GCD_LD;
        end
      end
      ST_MUL_L:   state_d = ST_MUL_R;
      ST_MUL_R:   state_d = ST_DONE;
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o       = 1'b1;
    valid_o      = 1'b0;
    gcd_load     = 1'b0;
    div_load     = 1'b0;
    div_dividend = cur_den;
    mul_x        = rn_b_q;
    mul_y        = $signed({1'b0, rd_a_q});
    case (state_q)
      ST_IDLE:    busy_o = 1'b0;
      ST_GCD_LD:  gcd_load = 1'b1;
      ST_DIVN_LD: begin
        div_load     = 1'b1;
        div_dividend = cur_num;
      end
      ST_DIVD_LD: div_load = 1'b1;
      ST_MUL_L: begin
        mul_x = rn_a_q;
        mul_y = $signed({1'b0, rd_b_q});
      end
      ST_DONE:    valid_o = 1'b1;
      default:    busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        sel_q <= 1'b0;
        err_q <= zero_den;
      end else if ((state_q == ST_DIVD) && div_done) begin
        sel_q <= 1'b1;
      end
    end
  end

  frc_gcd #(
    .MagBits(MW)
  ) u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (gcd_load),
    .u_i    (cur_num),
    .v_i    (cur_den),
    .done_o (gcd_done),
    .gcd_o  (gcd_val)
  );

  frc_div #(
    .MagBits(MW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (div_load),
    .dividend_i (div_dividend),
    .divisor_i  (gcd_val),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign qn_ext = {1'b0, qn_q};
  assign rn_new = cur_neg ? (W'(0) - qn_ext) : qn_ext;
  assign mul_p  = mul_x * mul_y;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_na_q <= mag_of(na_v);
      mag_da_q <= mag_of(da_v);
      mag_nb_q <= mag_of(nb_v);
      mag_db_q <= mag_of(db_v);
      neg_na_q <= na_v[W-1];
      neg_da_q <= da_v[W-1];
      neg_nb_q <= nb_v[W-1];
      neg_db_q <= db_v[W-1];
    end
    if ((state_q == ST_DIVN) && div_done) begin
      qn_q <= div_quo;
    end
    if ((state_q == ST_DIVD) && div_done) begin
      if (sel_q) begin
        rn_b_q <= $signed(rn_new);
        rd_b_q <= div_quo;
      end else begin
        rn_a_q <= $signed(rn_new);
        rd_a_q <= div_quo;
      end
    end
    if (state_q == ST_MUL_L) begin
      left_q <= mul_p;
    end
    if (state_q == ST_MUL_R) begin
      right_q <= mul_p;
    end
  end

  assign eq = (rn_a_q == rn_b_q) && (rd_a_q == rd_b_q);
  assign gt = (left_q > right_q);

  always_comb begin
    red_num_a_o      = '0;
    red_den_a_o      = '0;
    red_num_b_o      = '0;
    red_den_b_o      = '0;
    is_equal_o       = 1'b0;
    a_greater_o      = 1'b0;
    max_num_o        = '0;
    max_den_o        = '0;
    zero_den_error_o = err_q;
    if (!err_q) begin
      red_num_a_o = 32'(rn_a_q);
      red_den_a_o = 31'(rd_a_q);
      red_num_b_o = 32'(rn_b_q);
      red_den_b_o = 31'(rd_b_q);
      is_equal_o  = eq;
      a_greater_o = gt;
      if (eq || gt) begin
        max_num_o = 32'(rn_a_q);
        max_den_o = 31'(rd_a_q);
      end else begin
        max_num_o = 32'(rn_b_q);
        max_den_o = 31'(rd_b_q);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/frc_checker.sv
// ----------------------------------------------------------------------------
// Fraction reduce and compare: port checker
// Watches the ports of the top level and flags results that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        valid_o,
  input wire logic [31:0] red_num_a_o,
  input wire logic [30:0] red_den_a_o,
  input wire logic [30:0] red_den_b_o,
  input wire logic        is_equal_o,
  input wire logic        a_greater_o,
  input wire logic [30:0] max_den_o,
  input wire logic        zero_den_error_o
);

  a_take_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("Block did not turn busy after taking a beat.");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("Result strobe lasted longer than one cycle.");

  a_error_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_den_error_o |-> red_num_a_o == '0 && max_den_o == '0 &&
      !is_equal_o && !a_greater_o)
    else $error("Error result carries non-zero fields.");

  a_den_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !zero_den_error_o |-> red_den_a_o != '0 && red_den_b_o != '0)
    else $error("Reduced denominator is zero.");

  a_eq_not_gt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_equal_o |-> !a_greater_o)
    else $error("Equal fractions reported as ordered.");

endmodule

bind fraction_reduce_and_compare frc_port_checker u_frc_checker (.*);

`default_nettype wire
